@@ rtl/alux_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alux_pkg - shared types and constants for the lux reporter
// Segment table, change divisors, float encoding constants, sequencer states.
// ----------------------------------------------------------------------------
package alux_pkg;

  localparam logic [3:0]  SEG_LAST      = 4'd14;
  localparam logic [7:0]  SAT_HIGH      = 8'd112;
  localparam logic [15:0] LUX_MAX       = 16'hFFFF;
  localparam logic [16:0] MANT_MAX      = 17'h007FF;
  localparam logic [3:0]  EXP_BASE      = 4'd7;   // 0x3800 >> 11
  localparam logic [3:0]  LOG_SEG_SPLIT = 4'd11;
  localparam logic [3:0]  FINE_SEG_END  = 4'd7;
  localparam logic [2:0]  MODE_OFF      = 3'd0;
  localparam logic [2:0]  MODE_TOP      = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV_REST,
    ST_ADD_REST,
    ST_DIV_FINE,
    ST_ADD_FINE,
    ST_CHECK,
    ST_DIV_THR,
    ST_DECIDE,
    ST_NORM,
    ST_DONE
  } state_t;

  function automatic logic [7:0] seg_bound(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'd0;
      4'd1:    b = 8'd9;
      4'd2:    b = 8'd17;
      4'd3:    b = 8'd27;
      4'd4:    b = 8'd40;
      4'd5:    b = 8'd53;
      4'd6:    b = 8'd66;
      4'd7:    b = 8'd79;
      4'd8:    b = 8'd88;
      4'd9:    b = 8'd96;
      4'd10:   b = 8'd101;
      4'd11:   b = 8'd106;
      4'd12:   b = 8'd109;
      4'd13:   b = 8'd112;
      default: b = 8'd255;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] change_div(input logic [2:0] mode);
    logic [7:0] d;
    case (mode)
      3'd0:    d = 8'd100;
      3'd1:    d = 8'd20;
      3'd2:    d = 8'd10;
      3'd3:    d = 8'd5;
      default: d = 8'd3;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/alux_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alux_in_if / alux_out_if - valid/ready channels of the lux reporter
// Input carries one ADC reading, output carries one lux report.
// ----------------------------------------------------------------------------
interface alux_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adc_high;
  logic [7:0] adc_low;

  modport source (output valid, output adc_high, output adc_low, input ready);
  modport sink   (input valid, input adc_high, input adc_low, output ready);
endinterface

interface alux_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] lux_value;
  logic [15:0] lux_float16;
  logic        value_changed;
  logic        send_request;

  modport source (output valid, output lux_value, output lux_float16,
                  output value_changed, output send_request, input ready);
  modport sink   (input valid, input lux_value, input lux_float16,
                  input value_changed, input send_request, output ready);
endinterface

@@ rtl/adc_to_lux_float16_reporter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_lux_float16_reporter - light sensor ADC to lux and bus float
// Piecewise-log lux conversion, 16-bit bus float encoding, change reporting.
// ----------------------------------------------------------------------------
// One item at a time: the next reading is accepted only after the current
// item is done, and later still while the previous report still waits in
// the output register. The segment search walks up to 13 table entries, one
// per cycle, and a single restoring divider, one quotient bit per cycle, is
// shared for the segment interpolation, the low-byte fine term and the change
// threshold (up to three divisions per item; a saturated reading skips the
// search and the first two divisions); normalization of the float mantissa
// takes at most five shifts. The finished report sits in an output register,
// so the next item is accepted while it waits to be taken.
module adc_to_lux_float16_reporter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  alux_in_if.sink    in_chan,
  alux_out_if.source out_chan
);
  import alux_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  mode_r;
  logic [15:0] last_r, last_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [15:0] lux_r, lux_nxt;
  logic        changed_r, changed_nxt;
  logic        send_r, send_nxt;
  logic [16:0] m_r, m_nxt;
  logic [2:0]  k_r, k_nxt;

  // shared divider
  logic [15:0] dvd_r, dvd_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic        div_last;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_lux_r, out_lux_nxt;
  logic [15:0] out_flt_r, out_flt_nxt;
  logic        out_chg_r, out_chg_nxt;
  logic        out_snd_r, out_snd_nxt;

  logic [7:0]  delta;
  logic [7:0]  rest;
  logic [3:0]  rest_sh;
  logic [2:0]  mode_sel;
  logic [15:0] diff;
  logic [15:0] thr;

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.lux_value     = out_lux_r;
  assign out_chan.lux_float16   = out_flt_r;
  assign out_chan.value_changed = out_chg_r;
  assign out_chan.send_request  = out_snd_r;

  assign delta    = seg_bound(n_r) - seg_bound(n_r - 4'd1);
  assign rest     = hi_r - seg_bound(n_r - 4'd1);
  assign rest_sh  = (n_r < LOG_SEG_SPLIT) ? (n_r + 4'd2) : (n_r - 4'd2);
  assign mode_sel = (mode_r > MODE_TOP) ? MODE_TOP : mode_r;
  assign diff     = (lux_r > last_r) ? (lux_r - last_r) : (last_r - lux_r);
  assign thr      = (q_r == 16'd0) ? 16'd1 : q_r;

  assign rem_sh   = {rem_r, dvd_r[15]};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_r});
  assign div_last = (cnt_r == 4'd15);

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    n_nxt         = n_r;
    lux_nxt       = lux_r;
    changed_nxt   = changed_r;
    send_nxt      = send_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_lux_nxt   = out_lux_r;
    out_flt_nxt   = out_flt_r;
    out_chg_nxt   = out_chg_r;
    out_snd_nxt   = out_snd_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == ST_DIV_REST || state_r == ST_DIV_FINE || state_r == ST_DIV_THR) begin
      rem_nxt = rem_ge ? 8'(rem_sh - {1'b0, dvs_r}) : rem_sh[7:0];
      q_nxt   = {q_r[14:0], rem_ge};
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = cnt_r + 4'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          hi_nxt = in_chan.adc_high;
          lo_nxt = in_chan.adc_low;
          n_nxt  = 4'd1;
          if (in_chan.adc_high >= SAT_HIGH) begin
            lux_nxt   = LUX_MAX;
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (n_r < SEG_LAST && hi_r >= seg_bound(n_r)) begin
          n_nxt = n_r + 4'd1;
        end else begin
          lux_nxt   = (n_r <= 4'd1) ? 16'd0 : (16'd2 << n_r);
          dvd_nxt   = 16'(16'(rest) << rest_sh);
          dvs_nxt   = delta;
          rem_nxt   = 8'd0;
          cnt_nxt   = 4'd0;
          state_nxt = ST_DIV_REST;
        end
      end
      ST_DIV_REST: begin
        if (div_last) begin
          state_nxt = ST_ADD_REST;
        end
      end
      ST_ADD_REST: begin
        lux_nxt = (n_r < LOG_SEG_SPLIT) ? (lux_r + q_r) : (lux_r + {q_r[11:0], 4'd0});
        if (n_r < FINE_SEG_END) begin
          dvd_nxt   = 16'(16'(lo_r) << (n_r + 4'd2));
          rem_nxt   = 8'd0;
          cnt_nxt   = 4'd0;
          state_nxt = ST_DIV_FINE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_DIV_FINE: begin
        if (div_last) begin
          state_nxt = ST_ADD_FINE;
        end
      end
      ST_ADD_FINE: begin
        lux_nxt   = lux_r + {8'd0, q_r[15:8]};
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        changed_nxt = (lux_r != last_r);
        send_nxt    = 1'b0;
        m_nxt       = {1'b0, lux_r} + 17'(lux_r >> 2) + 17'(lux_r >> 5);
        m_nxt       = m_nxt + 17'(lux_r >> 1) - {1'b0, lux_r};
        k_nxt       = 3'd0;
        if (mode_r != MODE_OFF) begin
          dvd_nxt   = last_r;
          dvs_nxt   = change_div(mode_sel);
          rem_nxt   = 8'd0;
          cnt_nxt   = 4'd0;
          state_nxt = ST_DIV_THR;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_DIV_THR: begin
        if (div_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (lux_r != last_r && diff >= thr) begin
          send_nxt = 1'b1;
          last_nxt = lux_r;
        end
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (m_r > MANT_MAX) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + 3'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_lux_nxt   = lux_r;
          out_flt_nxt   = {1'b0, EXP_BASE + {1'b0, k_r}, m_r[10:0]};
          out_chg_nxt   = changed_r;
          out_snd_nxt   = send_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_OFF;
      last_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    n_r       <= n_nxt;
    lux_r     <= lux_nxt;
    changed_r <= changed_nxt;
    send_r    <= send_nxt;
    m_r       <= m_nxt;
    k_r       <= k_nxt;
    dvd_r     <= dvd_nxt;
    dvs_r     <= dvs_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
    out_lux_r <= out_lux_nxt;
    out_flt_r <= out_flt_nxt;
    out_chg_r <= out_chg_nxt;
    out_snd_r <= out_snd_nxt;
  end

  a_send_implies_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_snd_r |-> out_chg_r)
    else $error("send request without a changed value");

  a_no_send_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mode_r == MODE_OFF) |-> !out_snd_r)
    else $error("send request while send on change is disabled");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_REST || state_r == ST_DIV_FINE || state_r == ST_DIV_THR)
    |-> (dvs_r != 8'd0))
    else $error("divider running with zero divisor");

  a_float_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> !out_flt_r[15] && (out_flt_r[14:11] >= EXP_BASE))
    else $error("float report out of range");

endmodule
